@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the priority queue.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is active.
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, but checked during reset as well.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/spq_pkg.sv @@
// Package of the sorted priority queue: widths, codes and cell types.
// No dependencies.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] prio;
		logic signed [DATA_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t item;
	} cell_ctl_t;

endpackage

@@ design/sorted_priority_queue_unit.sv @@
// Sorted priority queue, lowest priority first, built as a row of cells.
// The result of an item is registered and appears in the cycle after it is accepted.
// One item per cycle unless stalled; cells compare and shift in the same clock.
// s_tready drops only while a result waits in the output register and m_tready is low.
// Reset clears the entry count and the output valid; slot contents are not reset.
module sorted_priority_queue_unit #(
	parameter int CAPACITY = spq_pkg::CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // item_value [31:0], item_priority [63:32]
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // removed_value [31:0], entry_count [36:32], zero fill
	output logic [1:0]  m_tuser   // status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	spq_pkg::status_t         out_status_q;
	logic [spq_pkg::DATA_W-1:0] out_removed_q;
	logic [spq_pkg::COUNT_W-1:0] out_count_q;

	logic                     accept;
	logic                     is_full;
	logic                     is_empty;
	spq_pkg::cell_ctl_t       ctl;
	spq_pkg::entry_t          entries [CAPACITY];
	logic                     le_flags [CAPACITY];
	logic [CNT_W-1:0]         count_next;
	spq_pkg::status_t         status_next;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	assign ctl.item.value = s_tdata[31:0];
	assign ctl.item.prio  = s_tdata[63:32];
	assign ctl.ins = accept && (spq_pkg::cmd_t'(s_tuser) == spq_pkg::CMD_INSERT) && !is_full;
	assign ctl.rem = accept && (spq_pkg::cmd_t'(s_tuser) == spq_pkg::CMD_REMOVE) && !is_empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (count_q > CNT_W'(i)),
			.left_le    ((i == 0) ? 1'b1 : le_flags[(i == 0) ? 0 : i - 1]),
			.left_entry ((i == 0) ? ctl.item : entries[(i == 0) ? 0 : i - 1]),
			.right_entry(entries[(i == CAPACITY - 1) ? i : i + 1]),
			.le         (le_flags[i]),
			.entry      (entries[i])
		);
	end

	always_comb begin
		count_next  = count_q;
		status_next = spq_pkg::STATUS_OK;
		unique case (spq_pkg::cmd_t'(s_tuser))
			spq_pkg::CMD_INSERT: begin
				if (is_full) begin
					status_next = spq_pkg::STATUS_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			spq_pkg::CMD_REMOVE: begin
				if (is_empty) begin
					status_next = spq_pkg::STATUS_EMPTY;
				end else begin
					count_next = count_q - CNT_W'(1);
				end
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q  <= status_next;
			out_removed_q <= ctl.rem ? entries[0].value : '0;
			out_count_q   <= spq_pkg::COUNT_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_count_q, out_removed_q};

endmodule

@@ design/spq_cell.sv @@
// One slot of the sorted row: holds an entry, compares it with an incoming key
// and takes the incoming entry or data from its left or right neighbor. Depends on spq_pkg.
module spq_cell (
	input  logic              clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  logic              left_le,
	input  spq_pkg::entry_t   left_entry,
	input  spq_pkg::entry_t   right_entry,
	output logic              le,
	output spq_pkg::entry_t   entry
);

	spq_pkg::entry_t entry_q;

	assign le    = occupied && (entry_q.prio <= ctl.item.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!le) begin
				entry_q <= left_le ? ctl.item : left_entry;
			end
		end else if (ctl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ design/spq_checker.sv @@
// Port-level checker of the sorted priority queue and its bind to the top level.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic empty_res;
	logic full_res;

	assign empty_res = m_tvalid && (m_tuser == spq_pkg::STATUS_EMPTY);
	assign full_res  = m_tvalid && (m_tuser == spq_pkg::STATUS_FULL);

	`SPQ_ASSERT(a_result_held, m_tvalid && !m_tready |=> m_tvalid, "Result dropped while stalled.")
	`SPQ_ASSERT(a_result_follows, s_tvalid && s_tready |=> m_tvalid, "Accepted item gave no result.")
	`SPQ_ASSERT(a_empty_count, empty_res |-> (m_tdata[36:0] == '0), "Empty remove, nonzero fields.")
	`SPQ_ASSERT(a_full_value, full_res |-> (m_tdata[31:0] == '0), "Dropped insert, nonzero value.")

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench of sorted_priority_queue_unit: directed table, then random traffic.
// Expected results come from a queue-based predictor kept in the testbench.
// Depends on spq_pkg and the RTL of the block only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int RUN_LIMIT = 200000;
	localparam int OUTPUT_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 335;
	localparam int SEND_IDLE [0:3] = '{0, 62, 0, 11};
	localparam int RECV_STALL [0:3] = '{0, 0, 62, 11};

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		status_t              status;
		word_t                removed;
		logic [COUNT_W-1:0]   count;
	} queue_result_t;

	typedef struct {
		cmd_t               cmd;
		word_t              value;
		word_t              prio;
		int                 reps;
		int                 prio_step;
		bit                 typed;
		status_t            status;
		word_t              removed;
		logic [COUNT_W-1:0] count;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	word_t shadow_prio [$];
	word_t shadow_value [$];
	queue_result_t awaited_results [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_output_req = 1'b0;
	int items_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int full_drops = 0;
	int empty_removes = 0;
	int input_stall_cycles = 0;
	int cycle_count = 0;

	stim_row_t directed_rows [0:14];

	sorted_priority_queue_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still awaited",
				cycle_count, awaited_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic queue_result_t next_queue_result(cmd_t cmd, word_t val, word_t pri);
		queue_result_t res;
		int pos;
		res.status = STATUS_OK;
		res.removed = '0;
		if (cmd == CMD_INSERT) begin
			if (shadow_prio.size() >= CAPACITY) begin
				res.status = STATUS_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_prio.size() && shadow_prio[pos] <= pri)
					pos++;
				shadow_prio.insert(pos, pri);
				shadow_value.insert(pos, val);
			end
		end else if (shadow_prio.size() == 0) begin
			res.status = STATUS_EMPTY;
		end else begin
			res.removed = shadow_value.pop_front();
			void'(shadow_prio.pop_front());
		end
		res.count = COUNT_W'(shadow_prio.size());
		return res;
	endfunction

	function automatic word_t pick_prio();
		case ($urandom_range(0, 6))
			0, 1, 2: return $urandom();
			3, 4: return $urandom_range(0, 6) - 3;
			5: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom_range(0, 2000) - 1000;
		endcase
	endfunction

	// Called at a rising edge; returns at the rising edge where the item was taken.
	task automatic offer_item(input cmd_t cmd, input word_t val, input word_t pri);
		bit took;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {pri, val};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		awaited_results.push_back(next_queue_result(cmd, val, pri));
		items_sent++;
	endtask

	task automatic run_random(input int quota);
		int goal;
		int n;
		int i;
		word_t p0;
		word_t p1;
		goal = items_sent + quota;
		while (items_sent < goal) begin
			case ($urandom_range(0, 3))
				0: begin
					n = $urandom_range(10, 30);
					for (i = 0; i < n; i++)
						offer_item(($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_REMOVE,
							$urandom(), pick_prio());
				end
				1: begin
					n = CAPACITY - shadow_prio.size() + $urandom_range(1, 3);
					for (i = 0; i < n; i++)
						offer_item(CMD_INSERT, $urandom(), pick_prio());
				end
				2: begin
					n = shadow_prio.size() + $urandom_range(1, 2);
					for (i = 0; i < n; i++)
						offer_item(CMD_REMOVE, $urandom(), $urandom());
				end
				default: begin
					p0 = pick_prio();
					p1 = pick_prio();
					n = $urandom_range(4, 10);
					for (i = 0; i < n; i++)
						offer_item(CMD_INSERT, $urandom(), $urandom_range(0, 1) ? p0 : p1);
					n = $urandom_range(2, 12);
					for (i = 0; i < n; i++)
						offer_item(CMD_REMOVE, $urandom(), $urandom());
				end
			endcase
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_output_req) begin
				hold_output_req = 1'b0;
				m_tready <= 1'b0;
				repeat (OUTPUT_HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(negedge clk) begin
		queue_result_t want;
		queue_result_t got;
		if (arst_n) begin
			if (s_tvalid && !s_tready)
				input_stall_cycles++;
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.removed = m_tdata[31:0];
				got.count = m_tdata[36:32];
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR at %0t: unexpected result status %0d value %0d count %0d",
							$realtime, got.status, got.removed, got.count);
				end else begin
					want = awaited_results.pop_front();
					results_checked++;
					if (want.status == STATUS_FULL)
						full_drops++;
					if (want.status == STATUS_EMPTY)
						empty_removes++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"ERROR at %0t: expected status %0d value %0d count %0d,",
								" got status %0d value %0d count %0d"}, $realtime,
								want.status, want.removed, want.count,
								got.status, got.removed, got.count);
					end
				end
			end
		end
	end

	initial begin
		int k;
		int ph;
		int directed_items;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_INSERT;
		m_tready <= 1'b0;
		directed_rows = '{
			'{CMD_REMOVE, 32'sd0, 32'sd0, 1, 0, 1'b1, STATUS_EMPTY, 32'sd0, 5'd0},
			'{CMD_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0, 1'b1, STATUS_OK, 32'sd0, 5'd1},
			'{CMD_INSERT, 32'sh8000_0000, 32'sh8000_0000, 1, 0, 1'b1, STATUS_OK, 32'sd0, 5'd2},
			'{CMD_INSERT, 32'sd5, 32'sd0, 1, 0, 1'b1, STATUS_OK, 32'sd0, 5'd3},
			'{CMD_INSERT, 32'sd6, 32'sd0, 1, 0, 1'b1, STATUS_OK, 32'sd0, 5'd4},
			'{CMD_REMOVE, 32'sh1234_5678, -32'sd9, 1, 0, 1'b1, STATUS_OK, 32'sh8000_0000, 5'd3},
			'{CMD_REMOVE, 32'sd0, 32'sd0, 1, 0, 1'b1, STATUS_OK, 32'sd5, 5'd2},
			'{CMD_REMOVE, 32'sd0, 32'sd0, 1, 0, 1'b1, STATUS_OK, 32'sd6, 5'd1},
			'{CMD_REMOVE, 32'sd0, 32'sd0, 1, 0, 1'b1, STATUS_OK, 32'sh7FFF_FFFF, 5'd0},
			'{CMD_REMOVE, -32'sd1, -32'sd1, 1, 0, 1'b1, STATUS_EMPTY, 32'sd0, 5'd0},
			'{CMD_INSERT, -32'sd1, -32'sd1, 1, 0, 1'b1, STATUS_OK, 32'sd0, 5'd1},
			'{CMD_INSERT, 32'sd100, 32'sd50, CAPACITY - 1, -1, 1'b0, STATUS_OK, 32'sd0, 5'd0},
			'{CMD_INSERT, 32'sd1234, 32'sd0, 1, 0, 1'b1, STATUS_FULL, 32'sd0, 5'd16},
			'{CMD_INSERT, 32'sh8000_0000, 32'sh8000_0000, 1, 0, 1'b1, STATUS_FULL, 32'sd0,
				5'd16},
			'{CMD_REMOVE, 32'sd0, 32'sd0, 1, 0, 1'b1, STATUS_OK, -32'sd1, 5'd15}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			for (k = 0; k < directed_rows[r].reps; k++) begin
				offer_item(directed_rows[r].cmd, directed_rows[r].value + k,
					directed_rows[r].prio + k * directed_rows[r].prio_step);
				if (directed_rows[r].typed)
					awaited_results[awaited_results.size() - 1] = '{directed_rows[r].status,
						directed_rows[r].removed, directed_rows[r].count};
			end
		end
		directed_items = items_sent;

		// The output side holds off while the input keeps pushing, so the block backs up.
		hold_output_req = 1'b1;
		for (k = 0; k < 40; k++)
			offer_item(($urandom_range(0, 99) < 70) ? CMD_INSERT : CMD_REMOVE,
				$urandom(), pick_prio());

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			stall_pct = RECV_STALL[ph];
			run_random(PHASE_ITEMS);
		end

		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d items (%0d directed) over four idle/stall mixes, checked %0d results.",
			items_sent, directed_items, results_checked);
		$display("Saw %0d inserts dropped when full, %0d removes on empty, %0d input stall cycles.",
			full_drops, empty_removes, input_stall_cycles);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
